### hdl/scb_pkg.sv
// Shared types and constants for the SPI command register bank.
package scb_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned MAX_REPLY = 64;
  localparam int unsigned REM_W     = $clog2(MAX_REPLY + 1);

  // Opcode byte values
  localparam logic [BYTE_W-1:0] OP_READ   = 8'd0;
  localparam logic [BYTE_W-1:0] OP_WRITE  = 8'd1;
  localparam logic [BYTE_W-1:0] OP_STREAM = 8'd2;

  // Position of the next byte inside a command frame
  typedef enum logic [1:0] {
    POS_OPCODE = 2'd0,
    POS_INDEX  = 2'd1,
    POS_THIRD  = 2'd2,
    POS_DRAIN  = 2'd3
  } frame_pos_e;

  // One reply byte from the engine toward the output register
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              last;
  } scb_res_t;

endpackage

### hdl/scb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/scb_engine.sv
// Frame parser and read/write sequencer in front of the register store.
module scb_engine #(
  parameter int unsigned STORE_BYTES = 64,
  localparam int unsigned AW = $clog2(STORE_BYTES)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     in_cmd_i,
  input  logic                     in_start_i,
  input  logic [scb_pkg::BYTE_W-1:0] in_byte_i,
  output logic                     ram_we_o,
  output logic [AW-1:0]            ram_waddr_o,
  output logic [scb_pkg::BYTE_W-1:0] ram_wdata_o,
  output logic                     ram_re_o,
  output logic [AW-1:0]            ram_raddr_o,
  input  logic [scb_pkg::BYTE_W-1:0] ram_rdata_i,
  output scb_pkg::scb_res_t        res_o,
  input  logic                     res_ready_i
);
  import scb_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_DATA
  } state_e;

  localparam logic [BYTE_W:0] STORE_LIM = (BYTE_W + 1)'(STORE_BYTES);
  localparam logic [BYTE_W:0] REPLY_LIM = (BYTE_W + 1)'(MAX_REPLY);

  state_e               state_q, state_d;
  frame_pos_e           pos_q, pos_d, pos_eff;
  logic [BYTE_W-1:0]    opcode_q, opcode_d;
  logic [BYTE_W-1:0]    index_q, index_d;
  logic [BYTE_W-1:0]    cur_q, cur_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic                 zero_q, zero_d;
  logic [STORE_BYTES-1:0] valid_q, valid_d;

  logic                 accept;
  logic                 idx_in_range;
  logic [BYTE_W:0]      stop;
  logic [BYTE_W:0]      span;
  logic [REM_W-1:0]     len;
  logic                 res_last;

  assign accept       = in_valid_i && (state_q == ST_IDLE);
  assign in_ready_o   = (state_q == ST_IDLE);
  assign pos_eff      = in_start_i ? POS_OPCODE : pos_q;
  assign idx_in_range = {1'b0, index_q} < STORE_LIM;
  assign stop         = ({1'b0, in_byte_i} > STORE_LIM) ? STORE_LIM : {1'b0, in_byte_i};
  assign span         = stop - {1'b0, index_q};
  assign len          = (span > REPLY_LIM) ? REM_W'(MAX_REPLY) : span[REM_W-1:0];
  assign res_last     = (rem_q == REM_W'(1));

  assign res_o.valid = (state_q == ST_DATA);
  assign res_o.data  = zero_q ? '0 : ram_rdata_i;
  assign res_o.last  = res_last;

  assign ram_wdata_o = in_byte_i;

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    opcode_d    = opcode_q;
    index_d     = index_q;
    cur_d       = cur_q;
    rem_d       = rem_q;
    zero_d      = zero_q;
    valid_d     = valid_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = index_q[AW-1:0];
    ram_re_o    = 1'b0;
    ram_raddr_o = index_q[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_cmd_i) begin
          // clear event: every entry reads as zero again
          valid_d = '0;
        end else if (accept) begin
          unique case (pos_eff)
            POS_OPCODE: begin
              opcode_d = in_byte_i;
              pos_d    = POS_INDEX;
            end
            POS_INDEX: begin
              index_d = in_byte_i;
              pos_d   = POS_THIRD;
            end
            POS_THIRD: begin
              pos_d = POS_DRAIN;
              unique case (opcode_q)
                OP_READ: begin
                  ram_re_o = 1'b1;
                  cur_d    = index_q;
                  rem_d    = REM_W'(1);
                  zero_d   = !(idx_in_range && valid_q[index_q[AW-1:0]]);
                  state_d  = ST_DATA;
                end
                OP_WRITE: begin
                  if (idx_in_range) begin
                    ram_we_o                  = 1'b1;
                    valid_d[index_q[AW-1:0]] = 1'b1;
                  end
                end
                OP_STREAM: begin
                  if ({1'b0, index_q} < stop) begin
                    ram_re_o = 1'b1;
                    cur_d    = index_q;
                    rem_d    = len;
                    zero_d   = !valid_q[index_q[AW-1:0]];
                    state_d  = ST_DATA;
                  end
                end
                default: begin
                end
              endcase
            end
            POS_DRAIN: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_DATA: begin
        if (res_ready_i) begin
          if (res_last) begin
            state_d = ST_IDLE;
          end else begin
            // advance to the next entry and fetch it
            cur_d       = cur_q + 1'b1;
            rem_d       = rem_q - 1'b1;
            ram_re_o    = 1'b1;
            ram_raddr_o = cur_d[AW-1:0];
            zero_d      = !valid_q[cur_d[AW-1:0]];
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pos_q    <= POS_OPCODE;
      opcode_q <= '0;
      index_q  <= '0;
      cur_q    <= '0;
      rem_q    <= '0;
      zero_q   <= 1'b1;
      valid_q  <= '0;
    end else begin
      state_q  <= state_d;
      pos_q    <= pos_d;
      opcode_q <= opcode_d;
      index_q  <= index_d;
      cur_q    <= cur_d;
      rem_q    <= rem_d;
      zero_q   <= zero_d;
      valid_q  <= valid_d;
    end
  end

  a_data_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DATA) |-> (rem_q != '0))
    else $error("reply state entered with no bytes left");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> ({1'b0, index_q} < STORE_LIM))
    else $error("store write outside the bank");

  a_last_ends_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_ready_i && res_o.last) |=> (state_q == ST_IDLE))
    else $error("reply continued past its last byte");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o))
    else $error("store read and write issued together");

endmodule

### hdl/spi_command_register_bank.sv
// Top level of the SPI command register bank: store, sequencer and reply register.
// A read or stream command's third byte starts a store read; each reply byte is registered
//   in the store and the output register; stream bytes follow one per cycle unless stalled.
// Throughput: one input transaction per cycle outside a reply; the input is held off
//   until a reply's last byte is loaded into the output register.
// Reset: valid flags clear at once, so the store reads as zero; frame state returns to zero.
module spi_command_register_bank #(
  parameter int unsigned STORE_BYTES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0] s_axis_tuser,   // [0] cmd, [1] frame_start
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] tx_byte
  output logic       m_axis_tlast    // last_byte
);
  import scb_pkg::*;

  localparam int unsigned AW = $clog2(STORE_BYTES);

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  scb_res_t          res;
  logic              res_ready;

  logic              out_valid_q;
  logic [BYTE_W-1:0] out_data_q;
  logic              out_last_q;

  // Store contents; entries never written since reset or clear are masked to zero
  scb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Frame parsing and command sequencing
  scb_engine #(
    .STORE_BYTES(STORE_BYTES)
  ) u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser[0]),
    .in_start_i (s_axis_tuser[1]),
    .in_byte_i  (s_axis_tdata),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_re_o   (ram_re),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .res_o      (res),
    .res_ready_i(res_ready)
  );

  // Output register: take a new reply byte when empty or when the current one leaves
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  // Payload needs no reset; load only on a moving transaction
  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      out_data_q <= res.data;
      out_last_q <= res.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
